// ----- rtl/core/v3n_pkg.sv -----
// ----------------------------------------------------------------------------
// v3n_pkg
// shared widths, latencies and lane types for the vector normalizer
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int IN_W     = 16;             // component width, Q8.8
  localparam int MAG_W    = IN_W;           // magnitude of one component
  localparam int SQ_W     = 2 * MAG_W;      // square of one magnitude
  localparam int SUM_W    = SQ_W;           // sum of three squares fits
  localparam int ROOT_W   = SUM_W / 2;      // integer square root
  localparam int FRAC_W   = 14;             // unit components in Q1.14
  localparam int Q_W      = FRAC_W + 1;     // quotient up to 1.0
  localparam int DIV_W    = MAG_W + FRAC_W; // dividend mag << 14
  localparam int OUT_W    = 16;
  localparam int SQRT_LAT = ROOT_W;         // one root bit per stage
  localparam int ALIGN    = SQRT_LAT + 1;   // sum stage plus root stages
  localparam int LAT      = 2 + SQRT_LAT + Q_W;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } lane_t;

endpackage

// ----- rtl/core/v3n_square_lane.sv -----
// ----------------------------------------------------------------------------
// v3n_square_lane
// splits one component into sign and magnitude and squares the magnitude
// ----------------------------------------------------------------------------
module v3n_square_lane (
  input  logic                        clk,
  input  logic                        adv,
  input  logic signed [v3n_pkg::IN_W-1:0] comp,
  output v3n_pkg::lane_t              lane,
  output logic [v3n_pkg::SQ_W-1:0]    sq
);
  import v3n_pkg::*;

  logic [MAG_W-1:0] mag;
  lane_t            lane_r;
  logic [SQ_W-1:0]  sq_r;

  assign mag = comp[IN_W-1] ? MAG_W'(-comp) : MAG_W'(comp);

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r.neg <= comp[IN_W-1];
      lane_r.mag <= mag;
      sq_r       <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  assign lane = lane_r;
  assign sq   = sq_r;

endmodule

// ----- rtl/core/v3n_isqrt.sv -----
// ----------------------------------------------------------------------------
// v3n_isqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module v3n_isqrt (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [v3n_pkg::SUM_W-1:0]  sum,
  output logic [v3n_pkg::ROOT_W-1:0] root
);
  import v3n_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [SUM_W-1:0]  n_r    [SQRT_LAT];
  logic [REM_W-1:0]  rem_r  [SQRT_LAT];
  logic [ROOT_W-1:0] root_r [SQRT_LAT];

  for (genvar s = 0; s < SQRT_LAT; s++) begin : g_stage
    logic [SUM_W-1:0]  n_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  test;
    logic              ge;

    if (s == 0) begin : g_first
      assign n_in    = sum;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    assign trial = {rem_in, n_in[SUM_W-1 -: 2]};
    assign test  = {2'b00, root_in, 2'b01};
    assign ge    = trial >= test;

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[s]    <= n_in << 2;
        rem_r[s]  <= ge ? REM_W'(trial - test) : REM_W'(trial);
        root_r[s] <= {root_in[ROOT_W-2:0], ge};
      end
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

// ----- rtl/core/v3n_div_lane.sv -----
// ----------------------------------------------------------------------------
// v3n_div_lane
// pipelined restoring divide of one magnitude by the length, signed result
// ----------------------------------------------------------------------------
module v3n_div_lane (
  input  logic                       clk,
  input  logic                       adv,
  input  v3n_pkg::lane_t             lane,
  input  logic [v3n_pkg::ROOT_W-1:0] len,
  output logic [v3n_pkg::OUT_W-1:0]  unit
);
  import v3n_pkg::*;

  lane_t             dly_r  [ALIGN];
  logic [DIV_W-1:0]  rem_r  [Q_W];
  logic [Q_W-1:0]    q_r    [Q_W];
  logic [ROOT_W-1:0] len_r  [Q_W];
  logic              neg_r  [Q_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= lane;
      for (int k = 1; k < ALIGN; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [DIV_W-1:0]  rem_in;
    logic [Q_W-1:0]    q_in;
    logic [ROOT_W-1:0] len_in;
    logic              neg_in;
    logic [DIV_W-1:0]  dv;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = {dly_r[ALIGN-1].mag, {FRAC_W{1'b0}}};
      assign q_in   = '0;
      assign len_in = len;
      assign neg_in = dly_r[ALIGN-1].neg;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign q_in   = q_r[s-1];
      assign len_in = len_r[s-1];
      assign neg_in = neg_r[s-1];
    end

    assign dv = DIV_W'(len_in) << B;
    assign ge = rem_in >= dv;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= ge ? rem_in - dv : rem_in;
        q_r[s]   <= q_in | (Q_W'(ge) << B);
        len_r[s] <= len_in;
        neg_r[s] <= neg_in;
      end
    end
  end

  logic [OUT_W-1:0] q_ext;
  assign q_ext = (len_r[Q_W-1] == '0) ? '0 : OUT_W'(q_r[Q_W-1]);
  assign unit  = neg_r[Q_W-1] ? -q_ext : q_ext;

endmodule

// ----- rtl/core/vec3_normalize.sv -----
// ----------------------------------------------------------------------------
// vec3_normalize
// length and unit vector of one Q8.8 3d vector per beat
//
//   channel  dir  payload
//   in_      in   tdata = x, y, z (Q8.8)
//   out_     out  tdata = length, unit x, y, z; tuser = zero flag
//
// one beat accepted per cycle unless the output stalls; the result passes
// square, sum, 16 root stages, 15 divide stages and the output register
// reset clears only the valid bits; data registers are not reset
// a stalled output freezes the whole pipeline; in_tready follows it
// ----------------------------------------------------------------------------
module vec3_normalize (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_in, y_in, z_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // length_out, unit_x, unit_y, unit_z
  output logic        out_tuser   // zero_vector
);
  import v3n_pkg::*;

  logic              adv;
  logic [LAT-1:0]    vld_r;
  lane_t             lane   [3];
  logic [SQ_W-1:0]   sq     [3];
  logic [OUT_W-1:0]  unit   [3];
  logic [SUM_W-1:0]  sum_r;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] len_dly_r [Q_W];
  logic              out_valid_r;
  logic [63:0]       out_data_r;
  logic              out_zero_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3n_square_lane u_sq (
      .clk  (clk),
      .adv  (adv),
      .comp (in_tdata[i*IN_W +: IN_W]),
      .lane (lane[i]),
      .sq   (sq[i])
    );

    v3n_div_lane u_div (
      .clk  (clk),
      .adv  (adv),
      .lane (lane[i]),
      .len  (root),
      .unit (unit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sq[0] + sq[1] + sq[2];
    end
  end

  v3n_isqrt u_isqrt (
    .clk  (clk),
    .adv  (adv),
    .sum  (sum_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      len_dly_r[0] <= root;
      for (int k = 1; k < Q_W; k++) begin
        len_dly_r[k] <= len_dly_r[k-1];
      end
      out_data_r <= {unit[2], unit[1], unit[0], OUT_W'(len_dly_r[Q_W-1])};
      out_zero_r <= len_dly_r[Q_W-1] == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_tvalid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  a_zero_units : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:16] == '0)
    else $error("zero vector with nonzero unit components");

  a_zero_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == (out_tdata[15:0] == '0))
    else $error("zero flag disagrees with length");

  a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:16]) <= 16384 &&
                    $signed(out_tdata[31:16]) >= -16384))
    else $error("unit x out of range");

  a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule
